// File: rtl/hpq_pkg.sv
// ----------------------------------------------------------------------------
// hpq_pkg
// Shared types and constants of the binary max-heap priority queue.
// ----------------------------------------------------------------------------
package hpq_pkg;

  localparam int CAPACITY = 64;
  localparam int TAG_BITS = 16;
  localparam int PRIO_W   = 3;
  localparam int DATE_W   = 27;
  localparam int ARR_W    = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CHILD_W  = CNT_W + 1;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [PRIO_W-1:0]   prio;
    logic [DATE_W-1:0]   date;
    logic [ARR_W-1:0]    arrival;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    entry_t            data;
  } wr_req_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

endpackage

// File: rtl/hpq_if.sv
// ----------------------------------------------------------------------------
// hpq_if
// Valid/ready channels carrying request and response words of the queue.
// ----------------------------------------------------------------------------
interface hpq_req_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [hpq_pkg::PRIO_W-1:0]    entry_priority;
  logic [hpq_pkg::DATE_W-1:0]    entry_date;
  logic [hpq_pkg::TAG_BITS-1:0]  entry_tag;

  modport source (output valid, opcode, entry_priority, entry_date, entry_tag,
                  input ready);
  modport sink   (input valid, opcode, entry_priority, entry_date, entry_tag,
                  output ready);
endinterface

interface hpq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [hpq_pkg::PRIO_W-1:0]    top_priority;
  logic [hpq_pkg::DATE_W-1:0]    top_date;
  logic [hpq_pkg::TAG_BITS-1:0]  top_tag;
  logic [hpq_pkg::CNT_W-1:0]     entry_count;
  logic                          is_empty;
  hpq_pkg::status_t              status;

  modport source (output valid, top_priority, top_date, top_tag, entry_count,
                  is_empty, status, input ready);
  modport sink   (input valid, top_priority, top_date, top_tag, entry_count,
                  is_empty, status, output ready);
endinterface

// File: rtl/hpq_store.sv
// ----------------------------------------------------------------------------
// hpq_store
// Heap entry memory: one write port, two read ports with registered data.
// ----------------------------------------------------------------------------
module hpq_store (
  input  logic             clk,
  input  hpq_pkg::wr_req_t wr,
  input  hpq_pkg::rd_req_t rda,
  input  hpq_pkg::rd_req_t rdb,
  output hpq_pkg::entry_t  rda_data,
  output hpq_pkg::entry_t  rdb_data
);
  import hpq_pkg::*;

  entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rda.en) begin
      rda_data <= mem[rda.addr];
    end
    if (rdb.en) begin
      rdb_data <= mem[rdb.addr];
    end
  end

endmodule

// File: rtl/hpq_rank.sv
// ----------------------------------------------------------------------------
// hpq_rank
// Shared ordering compare: class, then date score, then arrival number.
// ----------------------------------------------------------------------------
module hpq_rank (
  input  hpq_pkg::entry_t a,
  input  hpq_pkg::entry_t b,
  output logic            above
);
  import hpq_pkg::*;

  assign above = {a.prio, a.date, a.arrival} > {b.prio, b.date, b.arrival};

endmodule

// File: rtl/binary_max_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue
// Fixed-capacity max-heap with insert and remove-top, sifted by a sequencer.
// Insert sifts the new entry up from the end, one parent compare per level.
// Remove takes the last entry to the root and sifts it down, two compares per
// child level; a rejected insert or an empty remove goes straight to its response.
// One request at a time; a response word still waiting holds the block busy.
// Reset empties the heap and clears the arrival counter; no memory sweep.
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue (
  input logic       clk,
  input logic       rst,
  hpq_req_if.sink   req,
  hpq_rsp_if.source rsp
);
  import hpq_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_UP_CMP  = 8'b0000_0010,
    S_DN_LOAD = 8'b0000_0100,
    S_DN_CMP1 = 8'b0000_1000,
    S_DN_CMP2 = 8'b0001_0000,
    S_PUT     = 8'b0010_0000,
    S_DONE    = 8'b0100_0000
  } state_t;

  state_t             state, state_next;
  logic [CNT_W-1:0]   size, size_next;
  logic [ARR_W-1:0]   arrival, arrival_next;
  entry_t             x, x_next;
  entry_t             child, child_next;
  logic [ADDR_W-1:0]  pos, pos_next;
  logic [ADDR_W-1:0]  par, par_next;
  logic [ADDR_W-1:0]  cidx, cidx_next;
  status_t            stat, stat_next;
  entry_t             top;

  logic               out_valid;
  entry_t             out_top;
  logic [CNT_W-1:0]   out_count;
  status_t            out_stat;

  wr_req_t            wr;
  rd_req_t            rda, rdb;
  entry_t             rda_data, rdb_data;
  entry_t             cmp_a, cmp_b;
  logic               above;
  logic [CHILD_W-1:0] lc, rc, cl, size_x;
  logic               out_load;

  hpq_store u_store (
    .clk      (clk),
    .wr       (wr),
    .rda      (rda),
    .rdb      (rdb),
    .rda_data (rda_data),
    .rdb_data (rdb_data)
  );

  hpq_rank u_rank (
    .a     (cmp_a),
    .b     (cmp_b),
    .above (above)
  );

  assign lc       = CHILD_W'({pos, 1'b1});
  assign rc       = lc + 1'b1;
  assign cl       = CHILD_W'({cidx, 1'b1});
  assign size_x   = CHILD_W'(size);
  assign out_load = (state == S_DONE) && (!out_valid || rsp.ready);

  always_comb begin
    state_next   = state;
    size_next    = size;
    arrival_next = arrival;
    x_next       = x;
    child_next   = child;
    pos_next     = pos;
    par_next     = par;
    cidx_next    = cidx;
    stat_next    = stat;
    wr           = '0;
    rda          = '0;
    rdb          = '0;
    cmp_a        = x;
    cmp_b        = rda_data;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (req.opcode == OP_INSERT) begin
            if (size >= CNT_W'(CAPACITY)) begin
              stat_next  = ST_FULL;
              state_next = S_DONE;
            end else begin
              arrival_next = arrival + 1'b1;
              x_next       = '{prio: req.entry_priority, date: req.entry_date,
                               arrival: arrival_next, tag: req.entry_tag};
              pos_next     = ADDR_W'(size);
              size_next    = size + 1'b1;
              stat_next    = ST_DONE;
              if (size == '0) begin
                state_next = S_PUT;
              end else begin
                par_next   = ADDR_W'((size - 1'b1) >> 1);
                rda.en     = 1'b1;
                rda.addr   = par_next;
                state_next = S_UP_CMP;
              end
            end
          end else begin
            if (size == '0) begin
              stat_next  = ST_EMPTY;
              state_next = S_DONE;
            end else begin
              stat_next  = ST_DONE;
              rda.en     = 1'b1;
              rda.addr   = ADDR_W'(size - 1'b1);
              size_next  = size - 1'b1;
              state_next = S_DN_LOAD;
            end
          end
        end
      end
      S_UP_CMP: begin
        if (above) begin
          wr.en    = 1'b1;
          wr.addr  = pos;
          wr.data  = rda_data;
          pos_next = par;
          if (par == '0) begin
            state_next = S_PUT;
          end else begin
            par_next = ADDR_W'((par - 1'b1) >> 1);
            rda.en   = 1'b1;
            rda.addr = par_next;
          end
        end else begin
          state_next = S_PUT;
        end
      end
      S_DN_LOAD: begin
        if (size == '0) begin
          state_next = S_DONE;
        end else begin
          x_next   = rda_data;
          pos_next = '0;
          if (CHILD_W'(1) < size_x) begin
            rda.en     = 1'b1;
            rda.addr   = ADDR_W'(1);
            rdb.en     = 1'b1;
            rdb.addr   = ADDR_W'(2);
            state_next = S_DN_CMP1;
          end else begin
            state_next = S_PUT;
          end
        end
      end
      S_DN_CMP1: begin
        cmp_a = rdb_data;
        cmp_b = rda_data;
        if ((rc < size_x) && above) begin
          child_next = rdb_data;
          cidx_next  = rc[ADDR_W-1:0];
        end else begin
          child_next = rda_data;
          cidx_next  = lc[ADDR_W-1:0];
        end
        state_next = S_DN_CMP2;
      end
      S_DN_CMP2: begin
        cmp_a = child;
        cmp_b = x;
        if (above) begin
          wr.en    = 1'b1;
          wr.addr  = pos;
          wr.data  = child;
          pos_next = cidx;
          if (cl < size_x) begin
            rda.en     = 1'b1;
            rda.addr   = cl[ADDR_W-1:0];
            rdb.en     = 1'b1;
            rdb.addr   = ADDR_W'(cl + 1'b1);
            state_next = S_DN_CMP1;
          end else begin
            state_next = S_PUT;
          end
        end else begin
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        wr.en      = 1'b1;
        wr.addr    = pos;
        wr.data    = x;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      size      <= '0;
      arrival   <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      size    <= size_next;
      arrival <= arrival_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    x     <= x_next;
    child <= child_next;
    pos   <= pos_next;
    par   <= par_next;
    cidx  <= cidx_next;
    stat  <= stat_next;
    if (wr.en && (wr.addr == '0)) begin
      top <= wr.data;
    end
    if (out_load) begin
      out_top   <= (size == '0) ? '0 : top;
      out_count <= size;
      out_stat  <= stat;
    end
  end

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.top_priority = out_top.prio;
  assign rsp.top_date     = out_top.date;
  assign rsp.top_tag      = out_top.tag;
  assign rsp.entry_count  = out_count;
  assign rsp.is_empty     = (out_count == '0);
  assign rsp.status       = out_stat;

  a_size_bound: assert property (@(posedge clk) disable iff (rst)
    size <= CNT_W'(CAPACITY))
    else $error("heap size beyond capacity");

  a_write_in_heap: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (CNT_W'(wr.addr) < size))
    else $error("store write outside held entries");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status == ST_FULL)) |-> (rsp.entry_count == CNT_W'(CAPACITY)))
    else $error("full status with heap not full");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status == ST_EMPTY)) |-> rsp.is_empty)
    else $error("empty status with entries held");

  a_empty_top: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.is_empty) |->
      ((rsp.top_priority == '0) && (rsp.top_date == '0) && (rsp.top_tag == '0)))
    else $error("empty response shows a top entry");

endmodule
